[hdl/pvm_pkg.sv]
// pvm_pkg: shared widths, register indexes and types for the pot velocity mapper.
// Used by every module of the block; depends on nothing.
package pvm_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int SAMPLE_W     = 12;
	localparam int FS_W         = 15;
	localparam int VEL_W        = 16;
	localparam int SPAN_W       = 17;
	localparam int NUM_W        = SAMPLE_W + FS_W;
	localparam int CNT_W        = $clog2(NUM_W);
	localparam int QDEPTH       = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 15;

	localparam logic [CFG_IDX_W-1:0] REG_REST_POINT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REST_BAND   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_BAND = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 2'd3;

	localparam logic [SAMPLE_W-1:0] REST_POINT_RST  = 12'd3106;
	localparam logic [SAMPLE_W-1:0] REST_BAND_RST   = 12'd100;
	localparam logic [SAMPLE_W-1:0] CHANGE_BAND_RST = 12'd10;
	localparam logic [FS_W-1:0]     FULL_SCALE_RST  = 15'd12800;

	typedef struct packed {
		logic [SAMPLE_W-1:0] rest_point;
		logic [SAMPLE_W-1:0] rest_band;
		logic [SAMPLE_W-1:0] change_band;
		logic [FS_W-1:0]     full_scale;
	} cfg_t;

	typedef enum logic {
		CMD_ZERO,
		CMD_SCALE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic                neg;
		logic [SAMPLE_W-1:0] excess;
		logic [SPAN_W-1:0]   span;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_OUT
	} back_state_t;

endpackage

[hdl/pvm_front.sv]
// pvm_front: accepts samples, tracks the previous sample, drops small changes and
// classifies each kept sample into a zero or scale command. Depends on pvm_pkg.
module pvm_front #(
	parameter int ADC_BITS = pvm_pkg::ADC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pvm_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pvm_pkg::SAMPLE_W-1:0]  sample,
	input  pvm_pkg::qstat_t               qstat,
	output logic                          push,
	output pvm_pkg::cmd_t                 cmd
);
	import pvm_pkg::*;

	localparam int KEEP = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
	localparam int SX_W = SPAN_W + 1;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((33'd1 << KEEP) - 33'd1);
	localparam logic signed [SX_W-1:0] ADC_TOP = SX_W'((33'd1 << ADC_BITS) - 33'd1);

	logic [SAMPLE_W-1:0] prev_q;
	logic                seeded_q;
	logic [SAMPLE_W-1:0] s;
	logic [SAMPLE_W-1:0] delta;
	logic                accept;
	logic signed [SX_W-1:0] adc_x;
	logic signed [SX_W-1:0] hi_x;
	logic signed [SX_W-1:0] lo_x;
	logic signed [SX_W-1:0] span_hi;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;
	assign s        = sample & SAMPLE_MASK;
	assign delta    = (s >= prev_q) ? (s - prev_q) : (prev_q - s);
	assign push     = accept && seeded_q && !(delta < cfg.change_band);

	assign adc_x   = $signed(SX_W'(s));
	assign hi_x    = $signed(SX_W'(cfg.rest_point)) + $signed(SX_W'(cfg.rest_band));
	assign lo_x    = $signed(SX_W'(cfg.rest_point)) - $signed(SX_W'(cfg.rest_band));
	assign span_hi = ADC_TOP - hi_x;

	always_comb begin
		cmd.kind   = CMD_ZERO;
		cmd.neg    = 1'b0;
		cmd.excess = '0;
		cmd.span   = '0;
		if (adc_x > hi_x) begin
			if (span_hi > 0) begin
				cmd.kind   = CMD_SCALE;
				cmd.excess = SAMPLE_W'(adc_x - hi_x);
				cmd.span   = SPAN_W'(span_hi);
			end
		end else if (adc_x < lo_x) begin
			cmd.neg = 1'b1;
			if (lo_x > 0) begin
				cmd.kind   = CMD_SCALE;
				cmd.excess = SAMPLE_W'(lo_x - adc_x);
				cmd.span   = SPAN_W'(lo_x);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			seeded_q <= 1'b0;
		end else if (accept) begin
			prev_q   <= s;
			seeded_q <= 1'b1;
		end
	end

endmodule

[hdl/pvm_queue.sv]
// pvm_queue: short command queue between the front and back parts.
// Depends on pvm_pkg for the command type and depth.
module pvm_queue #(
	parameter int DEPTH = pvm_pkg::QDEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pvm_pkg::cmd_t   wr_cmd,
	input  logic            pop,
	output pvm_pkg::cmd_t   rd_cmd,
	output pvm_pkg::qstat_t qstat
);
	import pvm_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_cmd      = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/pvm_back.sv]
// pvm_back: executes commands: multiply by full scale, serial restoring divide,
// clamp and sign, then holds the velocity in the output register. Depends on pvm_pkg.
module pvm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pvm_pkg::FS_W-1:0]      full_scale,
	input  pvm_pkg::cmd_t                 head,
	input  pvm_pkg::qstat_t               qstat,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [pvm_pkg::VEL_W-1:0] velocity
);
	import pvm_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

	back_state_t state_q, state_d;

	logic [SAMPLE_W-1:0] dist_q;
	logic [SPAN_W-1:0]   span_q;
	logic                neg_q;
	logic [NUM_W-1:0]    work_q;
	logic [SPAN_W-1:0]   rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic signed [VEL_W-1:0] vel_q;

	logic [SPAN_W:0]     rem_sh;
	logic                ge;
	logic [SPAN_W:0]     rem_nx;
	logic [NUM_W-1:0]    work_nx;
	logic [FS_W-1:0]     q_clamp;
	logic signed [VEL_W-1:0] vel_nx;

	assign rem_sh  = {rem_q, work_q[NUM_W-1]};
	assign ge      = (rem_sh >= {1'b0, span_q});
	assign rem_nx  = ge ? (rem_sh - {1'b0, span_q}) : rem_sh;
	assign work_nx = {work_q[NUM_W-2:0], ge};
	assign q_clamp = (work_nx > NUM_W'(full_scale)) ? full_scale : work_nx[FS_W-1:0];
	assign vel_nx  = neg_q ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});

	assign velocity = vel_q;

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = (head.kind == CMD_SCALE) ? BK_MUL : BK_OUT;
				end
			end
			BK_MUL: begin
				state_d = BK_DIV;
			end
			BK_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dist_q <= head.excess;
			span_q <= head.span;
			neg_q  <= head.neg;
			vel_q  <= '0;
		end
		if (state_q == BK_MUL) begin
			work_q <= {{FS_W{1'b0}}, dist_q} * {{SAMPLE_W{1'b0}}, full_scale};
			rem_q  <= '0;
			cnt_q  <= '0;
		end
		if (state_q == BK_DIV) begin
			work_q <= work_nx;
			rem_q  <= rem_nx[SPAN_W-1:0];
			cnt_q  <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				vel_q <= vel_nx;
			end
		end
	end

endmodule

[hdl/pot_velocity_mapper_unit.sv]
// pot_velocity_mapper_unit: maps potentiometer samples to signed velocity commands.
// Flow: the back takes a new command only once the last result is taken, and divides
// one bit a cycle; the front keeps taking samples while the two-entry queue has room.
// Reset: asynchronous, active low; clears seeding, queue and back state, loads
// the configuration registers with their defaults.
module pot_velocity_mapper_unit #(
	parameter int ADC_BITS = pvm_pkg::ADC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pvm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pvm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [pvm_pkg::SAMPLE_W-1:0]       sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [pvm_pkg::VEL_W-1:0]   velocity
);
	import pvm_pkg::*;

	cfg_t   cfg_q;
	qstat_t qstat;
	cmd_t   wr_cmd;
	cmd_t   head;
	logic   q_push;
	logic   q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest_point  <= REST_POINT_RST;
			cfg_q.rest_band   <= REST_BAND_RST;
			cfg_q.change_band <= CHANGE_BAND_RST;
			cfg_q.full_scale  <= FULL_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REST_POINT:  cfg_q.rest_point  <= cfg_data[SAMPLE_W-1:0];
				REG_REST_BAND:   cfg_q.rest_band   <= cfg_data[SAMPLE_W-1:0];
				REG_CHANGE_BAND: cfg_q.change_band <= cfg_data[SAMPLE_W-1:0];
				REG_FULL_SCALE:  cfg_q.full_scale  <= cfg_data[FS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pvm_front #(
		.ADC_BITS (ADC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.qstat    (qstat),
		.push     (q_push),
		.cmd      (wr_cmd)
	);

	pvm_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (wr_cmd),
		.pop    (q_pop),
		.rd_cmd (head),
		.qstat  (qstat)
	);

	pvm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.full_scale (cfg_q.full_scale),
		.head       (head),
		.qstat      (qstat),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.velocity   (velocity)
	);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !qstat.full)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !qstat.empty)
		else $error("command queue read while empty");

	a_no_pop_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !q_pop)
		else $error("command taken while a result is pending");
`endif

endmodule
